// ----- hw/rtl/ice_pkg.sv -----
// Shared types, codes and helpers for the instruction candidate enumerator.
// No dependencies; used by ice_cell, the top level and the checker.
`timescale 1ns / 1ps

package ice_pkg;

	localparam int MAX_LEN = 15;
	localparam int IDX_W   = $clog2(MAX_LEN);
	localparam int POS_W   = 4;

	typedef enum logic [1:0] {
		CMD_START = 2'd0,
		CMD_NEXT  = 2'd1,
		CMD_CLEAR = 2'd2
	} cmd_t;

	typedef enum logic [1:0] {
		ST_BYTE      = 2'd0,
		ST_EXHAUSTED = 2'd1,
		ST_DONE      = 2'd2,
		ST_BAD_LEN   = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		CELL_HOLD   = 2'd0,
		CELL_BUMP   = 2'd1,
		CELL_CLEAR  = 2'd2,
		CELL_ROTATE = 2'd3
	} cell_op_t;

	// Broadcast to every cell of the row.
	typedef struct packed {
		cell_op_t         op;
		logic [POS_W-1:0] pos;
	} cell_ctl_t;

	// Prefix class of one byte.
	typedef struct packed {
		logic       pfx;
		logic [2:0] grp;
	} pfx_class_t;

	// Handed from each cell to its right neighbor.
	typedef struct packed {
		logic       run;
		logic       pfx;
		logic [2:0] grp;
	} cell_link_t;

	function automatic pfx_class_t classify(input logic [7:0] b);
		pfx_class_t c;
		c.pfx = 1'b1;
		case (b) inside
			8'hF0, 8'hF2, 8'hF3:                      c.grp = 3'd0;
			8'h2E, 8'h36, 8'h3E, 8'h26, 8'h64, 8'h65: c.grp = 3'd1;
			8'h66:                                    c.grp = 3'd2;
			8'h67:                                    c.grp = 3'd3;
			[8'h40:8'h4F]:                            c.grp = 3'd4;
			default: begin
				c.pfx = 1'b0;
				c.grp = 3'd0;
			end
		endcase
		return c;
	endfunction

endpackage

// ----- hw/rtl/ice_cell.sv -----
// One byte cell of the candidate row: holds its byte, bumps, clears or rotates it.
// Depends on ice_pkg for the control struct, the link struct and the prefix classifier.
`timescale 1ns / 1ps

module ice_cell (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic [ice_pkg::POS_W-1:0] cell_idx,
	input  ice_pkg::cell_ctl_t        ctl,
	input  logic [7:0]                rot_in,
	input  ice_pkg::cell_link_t       left_link,
	output ice_pkg::cell_link_t       right_link,
	output logic [7:0]                byte_val,
	output logic                      at_max,
	output logic                      bad
);

	logic [7:0]          byte_q;
	ice_pkg::pfx_class_t cls;
	logic                ge;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_q <= 8'd0;
		end else begin
			case (ctl.op)
				ice_pkg::CELL_BUMP: begin
					if (ctl.pos == cell_idx) byte_q <= byte_q + 8'd1;
				end
				ice_pkg::CELL_CLEAR: begin
					if (cell_idx >= ctl.pos) byte_q <= 8'd0;
				end
				ice_pkg::CELL_ROTATE: byte_q <= rot_in;
				default: ;
			endcase
		end
	end

	always_comb begin
		cls = ice_pkg::classify(byte_q);
		// order violation against the left neighbor inside the prefix run
		ge  = left_link.pfx & cls.pfx & (left_link.grp >= cls.grp);
		right_link.run = left_link.run & cls.pfx;
		right_link.pfx = cls.pfx;
		right_link.grp = cls.grp;
	end

	assign bad      = right_link.run & ge;
	assign byte_val = byte_q;
	assign at_max   = (byte_q == 8'hFF);

endmodule

// ----- hw/rtl/instruction_candidate_enumerator.sv -----
// Instruction candidate enumerator: a row of ice_cell byte cells under one sequencer.
// Depends on ice_pkg and ice_cell.
//
// Usage: one command beat on the input channel (command, start_length,
// clear_position) answers one or more beats on the output channel (status,
// byte_index, byte_value, last); last marks the final beat of a command.
// Start over, clear and unused codes answer one beat in the cycle after
// acceptance. A next command tries one candidate at a time (bump, then
// prefix check across the cell row); a byte that wraps moves the step left
// and the bump repeats there. An accepted candidate then streams out as
// MAX_LEN beats, one per cycle while the receiver takes them, by rotating
// the cell row once around. The block takes one command at a time: ready
// is high only when idle and the output register is free or draining. A
// stalled receiver holds the output register, and the row while it streams
// or reports exhaustion.
// Reset zeroes every candidate byte, the step position and the exhausted flag.
`timescale 1ns / 1ps

module instruction_candidate_enumerator (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] command,
	input  logic [3:0] start_length,
	input  logic [3:0] clear_position,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [1:0] status,
	output logic [3:0] byte_index,
	output logic [7:0] byte_value,
	output logic       last
);

	localparam int N = ice_pkg::MAX_LEN;
	localparam int W = ice_pkg::IDX_W;

	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_BUMP  = 4'b0010,
		S_CHECK = 4'b0100,
		S_EMIT  = 4'b1000
	} state_t;

	state_t                    state_q;
	logic [ice_pkg::POS_W-1:0] step_q;
	logic                      exhausted_q;
	logic [W-1:0]              cnt_q;

	logic       out_valid_q;
	logic [1:0] status_q;
	logic [3:0] byte_index_q;
	logic [7:0] byte_value_q;
	logic       last_q;

	ice_pkg::cell_ctl_t  ctl;
	ice_pkg::cell_link_t link [N+1];
	logic [7:0]          byte_val [N];
	logic [N-1:0]        at_max;
	logic [N-1:0]        bad;

	logic slot_ok;
	logic in_fire;
	logic wrap;
	logic bad_len;
	logic exhaust_now;
	logic out_load;

	assign link[0] = '{run: 1'b1, pfx: 1'b0, grp: 3'd0};

	for (genvar i = 0; i < N; i++) begin : g_cell
		ice_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.cell_idx   (ice_pkg::POS_W'(i)),
			.ctl        (ctl),
			.rot_in     (byte_val[(i + 1) % N]),
			.left_link  (link[i]),
			.right_link (link[i+1]),
			.byte_val   (byte_val[i]),
			.at_max     (at_max[i]),
			.bad        (bad[i])
		);
	end

	assign slot_ok     = !out_valid_q || out_ready;
	assign in_ready    = (state_q == S_IDLE) && slot_ok;
	assign in_fire     = in_valid && in_ready;
	assign wrap        = at_max[step_q[W-1:0]];
	assign bad_len     = (start_length == 4'd0) || ({1'b0, start_length} > 5'(N));
	assign exhaust_now = (state_q == S_BUMP) && wrap && (step_q == '0) && slot_ok;
	// every accepted command answers at once except a next that starts a search
	assign out_load    = (state_q == S_EMIT && slot_ok) || exhaust_now
		|| (in_fire && !(command == ice_pkg::CMD_NEXT && !exhausted_q));

	always_comb begin
		ctl.op  = ice_pkg::CELL_HOLD;
		ctl.pos = step_q;
		case (state_q)
			S_IDLE: begin
				if (in_fire && command == ice_pkg::CMD_CLEAR) begin
					ctl.op  = ice_pkg::CELL_CLEAR;
					ctl.pos = clear_position;
				end
			end
			S_BUMP: begin
				// the final wrap reports through the output register: hold until free
				if (!(wrap && step_q == '0) || slot_ok) ctl.op = ice_pkg::CELL_BUMP;
			end
			S_EMIT: begin
				if (slot_ok) ctl.op = ice_pkg::CELL_ROTATE;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			step_q      <= '0;
			exhausted_q <= 1'b0;
			cnt_q       <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						case (command)
							ice_pkg::CMD_START: begin
								if (!bad_len) begin
									step_q      <= start_length - 4'd1;
									exhausted_q <= 1'b0;
								end
							end
							ice_pkg::CMD_NEXT: begin
								if (!exhausted_q) state_q <= S_BUMP;
							end
							default: ;
						endcase
					end
				end
				S_BUMP: begin
					if (!wrap) begin
						state_q <= S_CHECK;
					end else if (step_q != '0) begin
						step_q <= step_q - 4'd1;
					end else if (slot_ok) begin
						exhausted_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				S_CHECK: begin
					cnt_q   <= '0;
					state_q <= (|bad) ? S_BUMP : S_EMIT;
				end
				S_EMIT: begin
					if (slot_ok) begin
						cnt_q <= cnt_q + W'(1);
						if (cnt_q == W'(N - 1)) state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// output payload; loaded whenever out_valid_q is, and also on a next that starts a search, when out_valid_q stays low
	always_ff @(posedge clk) begin
		if (state_q == S_EMIT && slot_ok) begin
			status_q     <= ice_pkg::ST_BYTE;
			byte_index_q <= 4'(cnt_q);
			byte_value_q <= byte_val[0];
			last_q       <= (cnt_q == W'(N - 1));
		end else if (exhaust_now) begin
			status_q     <= ice_pkg::ST_EXHAUSTED;
			byte_index_q <= 4'd0;
			byte_value_q <= 8'd0;
			last_q       <= 1'b1;
		end else if (in_fire) begin
			byte_index_q <= 4'd0;
			byte_value_q <= 8'd0;
			last_q       <= 1'b1;
			case (command)
				ice_pkg::CMD_START: status_q <= bad_len ? ice_pkg::ST_BAD_LEN : ice_pkg::ST_DONE;
				ice_pkg::CMD_NEXT:  status_q <= ice_pkg::ST_EXHAUSTED;
				default:            status_q <= ice_pkg::ST_DONE;
			endcase
		end
	end

	assign out_valid  = out_valid_q;
	assign status     = status_q;
	assign byte_index = byte_index_q;
	assign byte_value = byte_value_q;
	assign last       = last_q;

endmodule

// ----- hw/rtl/ice_checker.sv -----
// Port-level checker for the instruction candidate enumerator, bound to the top level.
// Depends on ice_pkg for status and command codes.
`timescale 1ns / 1ps

module ice_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic [1:0] command,
	input logic [3:0] start_length,
	input logic [3:0] clear_position,
	input logic       out_valid,
	input logic       out_ready,
	input logic [1:0] status,
	input logic [3:0] byte_index,
	input logic [7:0] byte_value,
	input logic       last
);

	// a stalled output beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status) && $stable(byte_index)
			&& $stable(byte_value) && $stable(last))
		else $error("output beat changed while stalled");

	a_status_beat: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ice_pkg::ST_BYTE |-> byte_index == 4'd0 && byte_value == 8'd0
			&& last)
		else $error("status beat carries byte data or is not last");

	a_last_byte: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ice_pkg::ST_BYTE |->
			last == (byte_index == 4'(ice_pkg::MAX_LEN - 1)))
		else $error("last flag does not match final byte index");

	a_bad_len: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && command == ice_pkg::CMD_START && start_length == 4'd0 |=>
			out_valid && status == ice_pkg::ST_BAD_LEN && last)
		else $error("zero length start over not rejected");

	a_clear_done: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && command == ice_pkg::CMD_CLEAR |=>
			out_valid && status == ice_pkg::ST_DONE && last)
		else $error("clear did not answer done");

endmodule

bind instruction_candidate_enumerator ice_checker u_ice_checker (.*);

// ----- dv/instruction_candidate_enumerator_tb.sv -----
// Self-checking testbench for the instruction candidate enumerator.
// Depends on ice_pkg and the RTL top level; drives commands, tracks candidate state and checks every beat.
`timescale 1ns / 1ps

module instruction_candidate_enumerator_tb;

	localparam logic [1:0] CMD_SPARE = 2'd3;
	localparam int NO_GROUP     = -1;
	localparam int QUIET_LIMIT  = 60000;
	localparam int DRAIN_CYCLES = 40;
	localparam int PHASE_ITEMS  = 56;
	localparam int DIR_N        = 21;

	typedef struct packed {
		ice_pkg::status_t st;
		logic [3:0]       idx;
		logic [7:0]       val;
		logic             fin;
	} beat_t;

	typedef struct packed {
		logic [1:0]       cmd;
		logic [3:0]       len;
		logic [3:0]       pos;
		logic             typed;
		ice_pkg::status_t st;
	} dir_row_t;

	logic       clk            = 1'b0;
	logic       arst_n         = 1'b0;
	logic       in_valid       = 1'b0;
	logic       in_ready;
	logic [1:0] command        = 2'd0;
	logic [3:0] start_length   = 4'd0;
	logic [3:0] clear_position = 4'd0;
	logic       out_valid;
	logic       out_ready      = 1'b0;
	logic [1:0] status;
	logic [3:0] byte_index;
	logic [7:0] byte_value;
	logic       last;

	// Candidate state as the block should hold it
	logic [7:0] cand_bytes [ice_pkg::MAX_LEN];
	logic [3:0] step_pos;
	bit         search_done;

	beat_t    awaited_beats [$];
	dir_row_t dir_rows [DIR_N];
	int       send_pcts  [4] = '{0, 77, 0, 11};
	int       stall_pcts [4] = '{0, 0, 77, 11};

	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	int err_count      = 0;
	int items_sent     = 0;
	int beats_checked  = 0;
	int runouts_seen   = 0;
	int quiet_cycles   = 0;

	instruction_candidate_enumerator DUT (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.command        (command),
		.start_length   (start_length),
		.clear_position (clear_position),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.status         (status),
		.byte_index     (byte_index),
		.byte_value     (byte_value),
		.last           (last)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic int prefix_group(input logic [7:0] b);
		case (b)
			8'hF0, 8'hF2, 8'hF3:                      return 0;
			8'h2E, 8'h36, 8'h3E, 8'h26, 8'h64, 8'h65: return 1;
			8'h66:                                    return 2;
			8'h67:                                    return 3;
			default:                                  return (b[7:4] == 4'h4) ? 4 : NO_GROUP;
		endcase
	endfunction

	// Leading prefix run must climb strictly through the groups
	function automatic bit prefix_run_ordered();
		int i;
		int g;
		int prev;
		prev = NO_GROUP;
		for (i = 0; i < ice_pkg::MAX_LEN; i++) begin
			g = prefix_group(cand_bytes[i]);
			if (g == NO_GROUP)
				return 1'b1;
			if (g <= prev)
				return 1'b0;
			prev = g;
		end
		return 1'b1;
	endfunction

	// Bump at the step position, carry left on wrap; 0 when byte 0 wraps
	function automatic bit step_to_next_candidate();
		int p;
		while (1'b1) begin
			p = (step_pos >= ice_pkg::MAX_LEN) ? ice_pkg::MAX_LEN - 1 : step_pos;
			cand_bytes[p] = cand_bytes[p] + 8'd1;
			if (cand_bytes[p] == 8'd0) begin
				if (p == 0) begin
					step_pos = 4'd0;
					return 1'b0;
				end
				step_pos = 4'(p - 1);
			end else begin
				step_pos = 4'(p);
				if (prefix_run_ordered())
					return 1'b1;
			end
		end
		return 1'b0;
	endfunction

	task automatic enumerate_command(input logic [1:0] cmd, input logic [3:0] len,
			input logic [3:0] pos, input logic typed, input ice_pkg::status_t typed_st);
		ice_pkg::status_t st;
		beat_t            b;
		int               i;
		st = ice_pkg::ST_DONE;
		case (cmd)
			ice_pkg::CMD_START: begin
				if (len == 0 || len > ice_pkg::MAX_LEN) begin
					st = ice_pkg::ST_BAD_LEN;
				end else begin
					step_pos    = len - 4'd1;
					search_done = 1'b0;
				end
			end
			ice_pkg::CMD_NEXT: begin
				if (search_done || !step_to_next_candidate()) begin
					search_done = 1'b1;
					st = ice_pkg::ST_EXHAUSTED;
				end else begin
					for (i = 0; i < ice_pkg::MAX_LEN; i++) begin
						b.st  = ice_pkg::ST_BYTE;
						b.idx = 4'(i);
						b.val = cand_bytes[i];
						b.fin = (i == ice_pkg::MAX_LEN - 1);
						awaited_beats.push_back(b);
					end
					return;
				end
			end
			ice_pkg::CMD_CLEAR: begin
				for (i = pos; i < ice_pkg::MAX_LEN; i++)
					cand_bytes[i] = 8'd0;
			end
			default: ;
		endcase
		if (typed)
			st = typed_st;
		b.st  = st;
		b.idx = 4'd0;
		b.val = 8'd0;
		b.fin = 1'b1;
		awaited_beats.push_back(b);
	endtask

	// Called at a falling edge; returns at the falling edge after the beat is taken
	task automatic issue_command(input logic [1:0] cmd, input logic [3:0] len,
			input logic [3:0] pos, input logic typed, input ice_pkg::status_t typed_st);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid       <= 1'b1;
		command        <= cmd;
		start_length   <= len;
		clear_position <= pos;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		enumerate_command(cmd, len, pos, typed, typed_st);
		items_sent++;
		@(negedge clk);
	endtask

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
		err_count++;
	endtask

	always @(negedge clk)
		out_ready <= ($urandom_range(99) >= recv_stall_pct);

	always @(posedge clk) begin
		beat_t want;
		if (arst_n && out_valid && out_ready) begin
			beats_checked++;
			if (awaited_beats.size() == 0) begin
				report_mismatch("beat with nothing awaited, status", status, 0);
			end else begin
				want = awaited_beats.pop_front();
				if (status !== want.st)
					report_mismatch("status", status, want.st);
				if (byte_index !== want.idx)
					report_mismatch("byte_index", byte_index, want.idx);
				if (byte_value !== want.val)
					report_mismatch("byte_value", byte_value, want.val);
				if (last !== want.fin)
					report_mismatch("last", last, want.fin);
				if (want.st == ice_pkg::ST_EXHAUSTED)
					runouts_seen++;
			end
		end
	end

	// Stop a hung run: count cycles in which neither channel moves a beat
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("%0t: no beat moved for %0d cycles", $realtime, QUIET_LIMIT);
			$display("RESULT: ERROR");
			$finish;
		end
	end

	initial begin
		int         ph;
		int         n;
		int         r;
		int         guard;
		logic [1:0] cmd;
		logic [3:0] len;
		logic [3:0] pos;

		for (n = 0; n < ice_pkg::MAX_LEN; n++)
			cand_bytes[n] = 8'd0;
		step_pos    = 4'd0;
		search_done = 1'b0;

		dir_rows = '{
			'{ice_pkg::CMD_START, 4'd0,  4'd0,  1'b1, ice_pkg::ST_BAD_LEN},
			'{ice_pkg::CMD_NEXT,  4'd0,  4'd0,  1'b0, ice_pkg::ST_BYTE},
			'{ice_pkg::CMD_START, 4'd15, 4'd15, 1'b1, ice_pkg::ST_DONE},
			'{ice_pkg::CMD_NEXT,  4'd15, 4'd15, 1'b0, ice_pkg::ST_BYTE},
			'{ice_pkg::CMD_NEXT,  4'd0,  4'd15, 1'b0, ice_pkg::ST_BYTE},
			'{ice_pkg::CMD_START, 4'd1,  4'd0,  1'b1, ice_pkg::ST_DONE},
			'{ice_pkg::CMD_NEXT,  4'd1,  4'd0,  1'b0, ice_pkg::ST_BYTE},
			'{ice_pkg::CMD_NEXT,  4'd15, 4'd0,  1'b0, ice_pkg::ST_BYTE},
			'{ice_pkg::CMD_NEXT,  4'd0,  4'd15, 1'b0, ice_pkg::ST_BYTE},
			'{ice_pkg::CMD_CLEAR, 4'd0,  4'd15, 1'b1, ice_pkg::ST_DONE},
			'{ice_pkg::CMD_NEXT,  4'd5,  4'd10, 1'b0, ice_pkg::ST_BYTE},
			'{ice_pkg::CMD_CLEAR, 4'd15, 4'd0,  1'b1, ice_pkg::ST_DONE},
			'{CMD_SPARE,          4'd15, 4'd15, 1'b1, ice_pkg::ST_DONE},
			'{CMD_SPARE,          4'd0,  4'd0,  1'b1, ice_pkg::ST_DONE},
			'{ice_pkg::CMD_START, 4'd2,  4'd7,  1'b1, ice_pkg::ST_DONE},
			'{ice_pkg::CMD_NEXT,  4'd10, 4'd5,  1'b0, ice_pkg::ST_BYTE},
			'{ice_pkg::CMD_NEXT,  4'd6,  4'd9,  1'b0, ice_pkg::ST_BYTE},
			'{ice_pkg::CMD_CLEAR, 4'd5,  4'd1,  1'b1, ice_pkg::ST_DONE},
			'{ice_pkg::CMD_START, 4'd0,  4'd15, 1'b1, ice_pkg::ST_BAD_LEN},
			'{ice_pkg::CMD_START, 4'd14, 4'd3,  1'b1, ice_pkg::ST_DONE},
			'{ice_pkg::CMD_NEXT,  4'd3,  4'd12, 1'b0, ice_pkg::ST_BYTE}
		};

		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		for (n = 0; n < DIR_N; n++)
			issue_command(dir_rows[n].cmd, dir_rows[n].len, dir_rows[n].pos,
				dir_rows[n].typed, dir_rows[n].st);

		// Random traffic: mostly next commands with the step parked on byte 0, so the
		// front byte walks toward its wrap; side commands leave byte 0 alone
		for (ph = 0; ph < 4; ph++) begin
			send_idle_pct  = send_pcts[ph];
			recv_stall_pct = stall_pcts[ph];
			issue_command(ice_pkg::CMD_START, 4'd1, 4'($urandom_range(15)), 1'b0,
				ice_pkg::ST_BYTE);
			for (n = 0; n < PHASE_ITEMS; n++) begin
				r   = $urandom_range(99);
				len = 4'($urandom_range(15));
				pos = 4'($urandom_range(15));
				if (r < 92) begin
					cmd = ice_pkg::CMD_NEXT;
				end else if (r < 95) begin
					cmd = ice_pkg::CMD_CLEAR;
					pos = 4'($urandom_range(15, 1));
				end else if (r < 97) begin
					cmd = ice_pkg::CMD_START;
					len = 4'($urandom_range(1));
				end else begin
					cmd = CMD_SPARE;
				end
				issue_command(cmd, len, pos, 1'b0, ice_pkg::ST_BYTE);
			end
		end

		// Walk byte 0 until it wraps, then poke the exhausted state
		issue_command(ice_pkg::CMD_START, 4'd1, 4'($urandom_range(15)), 1'b0, ice_pkg::ST_BYTE);
		guard = 0;
		while (!search_done && guard < 300) begin
			issue_command(ice_pkg::CMD_NEXT, 4'($urandom_range(15)), 4'($urandom_range(15)),
				1'b0, ice_pkg::ST_BYTE);
			guard++;
		end
		issue_command(ice_pkg::CMD_NEXT, 4'($urandom_range(15)), 4'($urandom_range(15)),
			1'b0, ice_pkg::ST_BYTE);
		issue_command(ice_pkg::CMD_CLEAR, 4'($urandom_range(15)), 4'($urandom_range(15)),
			1'b0, ice_pkg::ST_BYTE);
		issue_command(ice_pkg::CMD_NEXT, 4'($urandom_range(15)), 4'($urandom_range(15)),
			1'b0, ice_pkg::ST_BYTE);
		issue_command(ice_pkg::CMD_START, 4'd4, 4'($urandom_range(15)), 1'b0, ice_pkg::ST_BYTE);
		issue_command(ice_pkg::CMD_NEXT, 4'($urandom_range(15)), 4'($urandom_range(15)),
			1'b0, ice_pkg::ST_BYTE);
		issue_command(ice_pkg::CMD_NEXT, 4'($urandom_range(15)), 4'($urandom_range(15)),
			1'b0, ice_pkg::ST_BYTE);
		in_valid <= 1'b0;

		while (awaited_beats.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d commands and checked %0d result beats, %0d of them exhaustion answers,",
			items_sent, beats_checked, runouts_seen);
		$display("walking byte 0 to its wrap under no idling, an idle sender, a stalled receiver and both.");
		if (err_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

// ----- files.f -----
hw/rtl/ice_pkg.sv
hw/rtl/ice_cell.sv
hw/rtl/instruction_candidate_enumerator.sv
hw/rtl/ice_checker.sv
dv/instruction_candidate_enumerator_tb.sv
